FILE: hdl/wfp_pkg.sv
`default_nettype none

package wfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 63;
	localparam int unsigned KEY_W  = 32;

	// 7-bit length codes that select an extended length
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

endpackage

`default_nettype wire

FILE: hdl/websocket_frame_parser_top.sv
// WebSocket frame parser (RFC 6455 framing). One stream byte is taken per beat and
// each accepted byte yields exactly one result beat in the next cycle, held in an output
// register, so the block sustains one byte per clock while the output side keeps up.
// The header is decoded in place: FIN, RSV and opcode from the first byte, then the
// MASK bit and the 7-bit length code, a 16-bit or 64-bit big-endian extended length
// and an optional 4-byte masking key. Payload bytes come out unmasked with
// payload_valid set and the last byte of a frame carries frame_end; an empty frame
// flags frame_end on its last header byte. A 64-bit length with its top bit set
// raises length_error on its last length byte and the parser waits for a new frame.
// The header fields and the decoded length ride along on every result beat.
`default_nettype none

module websocket_frame_parser_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [wfp_pkg::BYTE_W-1:0]  in_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             payload_valid,
	output logic [wfp_pkg::BYTE_W-1:0]       payload_byte,
	output logic                             frame_end,
	output logic                             fin_bit,
	output logic [2:0]                       rsv_bits,
	output logic [3:0]                       frame_opcode,
	output logic                             mask_flag,
	output logic [wfp_pkg::LEN_W-1:0]        frame_payload_length,
	output logic                             length_error
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]                   phase_q, phase_d;
	logic [7:0]                   hdr_q, hdr_d;
	logic                         mask_q, mask_d;
	logic [3:0]                   len_left_q, len_left_d;
	logic [wfp_pkg::LEN_W-1:0]    len_q, len_d;
	logic [wfp_pkg::KEY_W-1:0]    key_q, key_d;
	logic [2:0]                   key_left_q, key_left_d;
	logic [wfp_pkg::LEN_W-1:0]    rem_q, rem_d;
	logic [1:0]                   idx_q, idx_d;

	logic                         res_pv, res_fend, res_lerr, len_done;
	logic [7:0]                   res_pb, key_byte;
	logic [6:0]                   code;

	logic                         out_valid_q;
	logic                         pv_q, fend_q, lerr_q;
	logic [7:0]                   pb_q;

	logic in_acc, out_acc;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign code     = in_byte[6:0];
	assign key_byte = key_q[{~idx_q, 3'b000} +: 8];

	always_comb begin
		phase_d    = phase_q;
		hdr_d      = hdr_q;
		mask_d     = mask_q;
		len_left_d = len_left_q;
		len_d      = len_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		rem_d      = rem_q;
		idx_d      = idx_q;
		res_pv     = 1'b0;
		res_pb     = '0;
		res_fend   = 1'b0;
		res_lerr   = 1'b0;
		len_done   = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				mask_d = in_byte[7];
				key_d  = '0;
				if (code == wfp_pkg::LEN_CODE_16) begin
					len_left_d = wfp_pkg::EXT16_BYTES;
					len_d      = '0;
					phase_d    = PH_EXTLEN;
				end else if (code == wfp_pkg::LEN_CODE_64) begin
					len_left_d = wfp_pkg::EXT64_BYTES;
					len_d      = '0;
					phase_d    = PH_EXTLEN;
				end else begin
					len_d    = {{(wfp_pkg::LEN_W-7){1'b0}}, code};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				// bit 55 of the accumulator is bit 63 of the 64-bit length and is shifted out here
				len_d      = {len_q[wfp_pkg::LEN_W-9:0], in_byte};
				len_left_d = len_left_q - 4'd1;
				if (len_left_q == 4'd1) begin
					if (len_q[wfp_pkg::LEN_W-8]) begin
						res_lerr = 1'b1;
						phase_d  = PH_HDR0;
					end else begin
						len_done = 1'b1;
					end
				end
			end
			PH_KEY: begin
				key_d      = {key_q[wfp_pkg::KEY_W-9:0], in_byte};
				key_left_d = key_left_q - 3'd1;
				if (key_left_q == 3'd1) begin
					idx_d = '0;
					if (len_q == '0) begin
						res_fend = 1'b1;
						phase_d  = PH_HDR0;
					end else begin
						rem_d   = len_q;
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res_pv = 1'b1;
				res_pb = mask_q ? (in_byte ^ key_byte) : in_byte;
				idx_d  = idx_q + 2'd1;
				rem_d  = rem_q - {{(wfp_pkg::LEN_W-1){1'b0}}, 1'b1};
				if (rem_q == {{(wfp_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
					res_fend = 1'b1;
					phase_d  = PH_HDR0;
				end
			end
			default: begin
				hdr_d      = in_byte;
				mask_d     = 1'b0;
				len_d      = '0;
				len_left_d = '0;
				key_left_d = '0;
				key_d      = '0;
				idx_d      = '0;
				phase_d    = PH_HDR1;
			end
		endcase
		if (len_done) begin
			idx_d = '0;
			if (mask_d) begin
				key_left_d = wfp_pkg::KEY_BYTES;
				phase_d    = PH_KEY;
			end else if (len_d == '0) begin
				res_fend = 1'b1;
				phase_d  = PH_HDR0;
			end else begin
				rem_d   = len_d;
				phase_d = PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			hdr_q      <= '0;
			mask_q     <= 1'b0;
			len_left_q <= '0;
			len_q      <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			rem_q      <= '0;
			idx_q      <= '0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			hdr_q      <= hdr_d;
			mask_q     <= mask_d;
			len_left_q <= len_left_d;
			len_q      <= len_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			rem_q      <= rem_d;
			idx_q      <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// header fields are read back from the state registers, so only the beat flags and the payload byte live here
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pv_q   <= res_pv;
			pb_q   <= res_pb;
			fend_q <= res_fend;
			lerr_q <= res_lerr;
		end
	end

	assign out_valid            = out_valid_q;
	assign payload_valid        = pv_q;
	assign payload_byte         = pb_q;
	assign frame_end            = fend_q;
	assign fin_bit              = hdr_q[7];
	assign rsv_bits             = hdr_q[6:4];
	assign frame_opcode         = hdr_q[3:0];
	assign mask_flag            = mask_q;
	assign frame_payload_length = len_q;
	assign length_error         = lerr_q;

	a_lerr_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && lerr_q) |-> (!pv_q && !fend_q))
		else $error("length error beat carries payload or frame end");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("payload phase with nothing left to count");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXTLEN) |-> (len_left_q != '0))
		else $error("extended length phase with no bytes left");

	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> (key_left_q != '0))
		else $error("key phase with no bytes left");

	a_payload_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_PAYLOAD) |=> (out_valid_q && pv_q))
		else $error("payload byte accepted without a payload beat");

endmodule

`default_nettype wire
